/* hw/rtl/bdq_pkg.sv */
// Shared types and codes for the bounded deque with delete by value.
// Used by bdq_mem and bounded_deque_with_delete_by_value_top; no dependencies.
package bdq_pkg;

	localparam int CAPACITY = 16;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef logic [1:0]               op_t;
	typedef logic [1:0]               status_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [SLOT_W-1:0]        slot_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam op_t OP_PUSH_FRONT = 2'd0;
	localparam op_t OP_PUSH_BACK  = 2'd1;
	localparam op_t OP_DELETE     = 2'd2;
	localparam op_t OP_DUMP       = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FULL      = 2'd1;
	localparam status_t ST_EMPTY     = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		slot_t raddr;
		logic  val_we;
		slot_t val_addr;
		data_t val_data;
		logic  nxt_we;
		slot_t nxt_addr;
		slot_t nxt_data;
		logic  prv_we;
		slot_t prv_addr;
		slot_t prv_data;
	} mem_req_t;

	typedef struct packed {
		data_t val;
		slot_t nxt;
		slot_t prv;
	} mem_rd_t;

endpackage

/* hw/rtl/bounded_deque_with_delete_by_value_top.sv */
// Top level of the bounded deque: command sequencer, list registers and result register.
// Depends on bdq_pkg and bdq_mem.
//
//   channel  | handshake            | payload
//   request  | req_valid, req_stall | op, value
//   result   | res_valid, res_stall | status, item, final_res
//
// One command at a time; req_stall is high from acceptance until the last beat is queued.
// Push writes and links the new slot; delete and dump walk the list, one slot per cycle,
// dump only while a beat can be taken; refused or empty commands emit just a status beat.
// The result register lets a new command start while the last beat waits.
// arst_n clears the list to empty; the memories need no clearing.
module bounded_deque_with_delete_by_value_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  bdq_pkg::op_t     op,
	input  bdq_pkg::data_t   value,
	output logic             res_valid,
	input  logic             res_stall,
	output bdq_pkg::status_t status,
	output bdq_pkg::data_t   item,
	output logic             final_res
);
	import bdq_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PUSH1  = 3'd1;
	localparam logic [2:0] S_PUSH2  = 3'd2;
	localparam logic [2:0] S_DEL    = 3'd3;
	localparam logic [2:0] S_UNLINK = 3'd4;
	localparam logic [2:0] S_DUMP   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]          state_q;
	op_t                 op_q;
	data_t               val_q;
	logic [CAPACITY-1:0] free_q;
	slot_t               head_q;
	slot_t               tail_q;
	cnt_t                count_q;
	slot_t               cur_q;
	cnt_t                idx_q;
	logic                hmatch_q;
	slot_t               vic_q;
	slot_t               vprev_q;
	slot_t               vnext_q;
	status_t             res_st_q;
	logic                res_valid_q;
	status_t             status_q;
	data_t               item_q;
	logic                final_q;

	mem_req_t mreq;
	mem_rd_t  mrd;
	slot_t    fs;
	logic     out_ok;
	logic     beat_load;
	logic     match;
	logic     last;
	logic     hm;
	logic     empty;

	bdq_mem u_mem (
		.clk (clk),
		.req (mreq),
		.rd  (mrd)
	);

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign final_res = final_q;

	assign out_ok    = !res_valid_q || !res_stall;
	assign beat_load = out_ok && ((state_q == S_DUMP) || (state_q == S_EMIT));
	assign match     = (mrd.val == val_q);
	assign last      = ((idx_q + CNT_W'(1)) == count_q);
	assign hm        = (idx_q == '0) ? match : hmatch_q;
	assign empty     = (count_q == '0);

	always_comb begin
		fs = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (free_q[k]) begin
				fs = SLOT_W'(k);
			end
		end
	end

	always_comb begin
		mreq = '0;
		mreq.raddr = cur_q;
		case (state_q)
			S_IDLE: begin
				mreq.raddr = head_q;
			end
			S_PUSH1: begin
				mreq.val_we   = 1'b1;
				mreq.val_addr = fs;
				mreq.val_data = val_q;
				mreq.nxt_we   = 1'b1;
				mreq.nxt_addr = fs;
				mreq.nxt_data = empty ? fs : head_q;
				mreq.prv_we   = 1'b1;
				mreq.prv_addr = fs;
				mreq.prv_data = empty ? fs : tail_q;
			end
			S_PUSH2: begin
				mreq.prv_we   = 1'b1;
				mreq.prv_addr = head_q;
				mreq.prv_data = vic_q;
				mreq.nxt_we   = 1'b1;
				mreq.nxt_addr = tail_q;
				mreq.nxt_data = vic_q;
			end
			S_DEL: begin
				mreq.raddr = mrd.nxt;
			end
			S_UNLINK: begin
				if (count_q != CNT_W'(1)) begin
					mreq.nxt_we   = 1'b1;
					mreq.nxt_addr = vprev_q;
					mreq.nxt_data = vnext_q;
					mreq.prv_we   = 1'b1;
					mreq.prv_addr = vnext_q;
					mreq.prv_data = vprev_q;
				end
			end
			S_DUMP: begin
				mreq.raddr = out_ok ? mrd.nxt : cur_q;
			end
			default: begin
				mreq.raddr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_PUSH_FRONT;
			val_q       <= '0;
			free_q      <= '1;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			hmatch_q    <= 1'b0;
			vic_q       <= '0;
			vprev_q     <= '0;
			vnext_q     <= '0;
			res_st_q    <= ST_OK;
			res_valid_q <= 1'b0;
			status_q    <= ST_OK;
			item_q      <= '0;
			final_q     <= 1'b0;
		end else begin
			if (beat_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= op;
						val_q    <= value;
						cur_q    <= head_q;
						idx_q    <= '0;
						hmatch_q <= 1'b0;
						case (op)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_PUSH1;
								end
							end
							OP_DELETE: begin
								if (empty) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_DEL;
								end
							end
							default: begin
								if (empty) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_DUMP;
								end
							end
						endcase
					end
				end
				S_PUSH1: begin
					free_q[fs] <= 1'b0;
					vic_q      <= fs;
					res_st_q   <= ST_OK;
					if (empty) begin
						head_q  <= fs;
						tail_q  <= fs;
						count_q <= CNT_W'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PUSH2;
					end
				end
				S_PUSH2: begin
					if (op_q == OP_PUSH_FRONT) begin
						head_q <= vic_q;
					end else begin
						tail_q <= vic_q;
					end
					count_q <= count_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_DEL: begin
					if (idx_q == '0) begin
						hmatch_q <= match;
						vic_q    <= cur_q;
						vprev_q  <= mrd.prv;
						vnext_q  <= mrd.nxt;
					end
					if (idx_q != '0 && match) begin
						vic_q   <= cur_q;
						vprev_q <= mrd.prv;
						vnext_q <= mrd.nxt;
						state_q <= S_UNLINK;
					end else if (last) begin
						if (hm) begin
							state_q <= S_UNLINK;
						end else begin
							res_st_q <= ST_NOT_FOUND;
							state_q  <= S_EMIT;
						end
					end
					cur_q <= mrd.nxt;
					idx_q <= idx_q + CNT_W'(1);
				end
				S_UNLINK: begin
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (vic_q == head_q) begin
							head_q <= vnext_q;
						end
						if (vic_q == tail_q) begin
							tail_q <= vprev_q;
						end
					end
					free_q[vic_q] <= 1'b1;
					count_q       <= count_q - CNT_W'(1);
					res_st_q      <= ST_OK;
					state_q       <= S_EMIT;
				end
				S_DUMP: begin
					if (out_ok) begin
						status_q <= ST_OK;
						item_q   <= mrd.val;
						final_q  <= last;
						cur_q    <= mrd.nxt;
						idx_q    <= idx_q + CNT_W'(1);
						if (last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (out_ok) begin
						status_q <= res_st_q;
						item_q   <= '0;
						final_q  <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/bdq_mem.sv */
// Element, next-link and previous-link memories of the deque.
// One write port per memory, one shared read address, registered read data. Uses bdq_pkg.
module bdq_mem (
	input  logic              clk,
	input  bdq_pkg::mem_req_t req,
	output bdq_pkg::mem_rd_t  rd
);
	import bdq_pkg::*;

	data_t val_mem [CAPACITY];
	slot_t nxt_mem [CAPACITY];
	slot_t prv_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.val_we) begin
			val_mem[req.val_addr] <= req.val_data;
		end
		if (req.nxt_we) begin
			nxt_mem[req.nxt_addr] <= req.nxt_data;
		end
		if (req.prv_we) begin
			prv_mem[req.prv_addr] <= req.prv_data;
		end
		rd.val <= val_mem[req.raddr];
		rd.nxt <= nxt_mem[req.raddr];
		rd.prv <= prv_mem[req.raddr];
	end

endmodule
